[rtl/sorted_table_binary_search_top_macros.svh]
// Assertion macros used by the sorted table search sequencer.
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, clocked on clk, off while rst_n is low
`define STBS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low
`define STBS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define STBS_ASSERT_IMP(label, ante, cons, msg)
`define STBS_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

[rtl/stbs_pkg.sv]
// Package: payload types, codes and default sizes of the sorted table search block.
package stbs_pkg;

  // Default table geometry
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int ENTRY_WIDTH_DEF = 32;

  // Fixed field widths of the transactions
  localparam int KEY_W   = 32;
  localparam int IDX_F_W = 10;
  localparam int SIZE_W  = 11;

  // Request codes
  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_SEARCH = 1'b1
  } stbs_req_t;

  // Search sequencer states
  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_SEARCH = 1'b1
  } stbs_state_t;

  // Input transaction
  typedef struct packed {
    stbs_req_t                 req_type;
    logic [IDX_F_W-1:0]        entry_index;
    logic signed [KEY_W-1:0]   entry_value;
    logic signed [KEY_W-1:0]   search_key;
  } stbs_in_t;

  // Result transaction
  typedef struct packed {
    logic               found;
    logic [IDX_F_W-1:0] match_index;
  } stbs_out_t;

endpackage

[rtl/stbs_mem.sv]
// Table memory: one write port, one read port with registered read data.
module stbs_mem #(
  parameter int DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
  parameter int WIDTH = stbs_pkg::ENTRY_WIDTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read entry, data valid in the cycle after rd_en
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/stbs_ctrl.sv]
// Search sequencer: walks the probe window over the table memory and returns the result.
`include "sorted_table_binary_search_top_macros.svh"

module stbs_ctrl #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
  parameter int ENTRY_WIDTH = stbs_pkg::ENTRY_WIDTH_DEF,
  localparam int IDX_W      = $clog2(TABLE_DEPTH),
  localparam int NW         = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  stbs_pkg::stbs_req_t             req_type,
  input  logic signed [stbs_pkg::KEY_W-1:0] search_key,
  input  logic [NW-1:0]                   num_entries,
  output logic                            rd_en,
  output logic [IDX_W-1:0]                rd_addr,
  input  logic [ENTRY_WIDTH-1:0]          rd_data,
  output logic                            out_strobe,
  output stbs_pkg::stbs_out_t             out_data
);
  import stbs_pkg::*;

  localparam int XW = (ENTRY_WIDTH > KEY_W) ? ENTRY_WIDTH : KEY_W;

  stbs_state_t             state_r, state_nxt;
  logic [NW-1:0]           low_r, low_nxt;
  logic [NW-1:0]           hi1_r, hi1_nxt;     // one past the highest candidate
  logic [NW-1:0]           mid_r, mid_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic                    strobe_r, strobe_nxt;
  stbs_out_t               res_r, res_nxt;

  logic signed [XW-1:0]    ent_x;
  logic signed [XW-1:0]    key_x;
  logic                    ent_lt;
  logic                    ent_eq;
  logic [NW-1:0]           cand_low;
  logic [NW-1:0]           cand_hi1;
  logic [NW-1:0]           cand_mid;
  logic                    cand_ok;

  // Compare the probed entry with the key, both sign-extended
  assign ent_x  = XW'($signed(rd_data));
  assign key_x  = XW'(key_r);
  assign ent_lt = (ent_x < key_x);
  assign ent_eq = (ent_x == key_x);

  // Narrow the window after a probe, or open it for a new search
  always_comb begin
    cand_low = low_r;
    cand_hi1 = hi1_r;
    unique case (state_r)
      ST_IDLE: begin
        cand_low = '0;
        cand_hi1 = num_entries;
      end
      ST_SEARCH: begin
        if (ent_lt) begin
          cand_low = mid_r + NW'(1);
        end else begin
          cand_hi1 = mid_r;
        end
      end
      default: begin
        cand_low = low_r;
      end
    endcase
  end

  assign cand_ok  = (cand_low < cand_hi1);
  assign cand_mid = cand_low + ((cand_hi1 - cand_low - NW'(1)) >> 1);

  assign busy    = (state_r != ST_IDLE);
  assign rd_addr = cand_mid[IDX_W-1:0];

  // Next state, probe issue and result
  always_comb begin
    state_nxt  = state_r;
    low_nxt    = low_r;
    hi1_nxt    = hi1_r;
    mid_nxt    = mid_r;
    key_nxt    = key_r;
    strobe_nxt = 1'b0;
    res_nxt    = res_r;
    rd_en      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start && (req_type == REQ_SEARCH)) begin
          key_nxt = search_key;
          if (cand_ok) begin
            rd_en     = 1'b1;
            low_nxt   = cand_low;
            hi1_nxt   = cand_hi1;
            mid_nxt   = cand_mid;
            state_nxt = ST_SEARCH;
          end else begin
            strobe_nxt = 1'b1;
            res_nxt    = '0;
          end
        end
      end
      ST_SEARCH: begin
        priority if (ent_eq) begin
          strobe_nxt          = 1'b1;
          res_nxt.found       = 1'b1;
          res_nxt.match_index = IDX_F_W'(mid_r);
          state_nxt           = ST_IDLE;
        end else if (cand_ok) begin
          rd_en   = 1'b1;
          low_nxt = cand_low;
          hi1_nxt = cand_hi1;
          mid_nxt = cand_mid;
        end else begin
          strobe_nxt = 1'b1;
          res_nxt    = '0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Window, key and result registers
  always_ff @(posedge clk) begin
    low_r <= low_nxt;
    hi1_r <= hi1_nxt;
    mid_r <= mid_nxt;
    key_r <= key_nxt;
    res_r <= res_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_data   = res_r;

  `STBS_ASSERT_IMP(a_window_open, state_r == ST_SEARCH, low_r < hi1_r, "empty window while searching")
  `STBS_ASSERT_IMP(a_mid_in_window, state_r == ST_SEARCH, mid_r >= low_r && mid_r < hi1_r, "probe outside window")
  `STBS_ASSERT_IMP(a_miss_zero_index, strobe_r && !res_r.found, res_r.match_index == '0, "miss with nonzero index")
  `STBS_ASSERT_NXT(a_search_proceeds, rst_n && start && !busy && req_type == REQ_SEARCH, state_r == ST_SEARCH || strobe_r, "search transaction dropped")
  `STBS_ASSERT_IMP(a_no_read_idle, rd_en && state_r == ST_IDLE, start && req_type == REQ_SEARCH, "stray probe while idle")

endmodule

[rtl/sorted_table_binary_search_top.sv]
// Search: start issues the first probe, then further probes follow, at most
// floor(log2(n))+1 probes for n entries (11 at 1024); the result strobes the
// cycle after the last probe compares, when busy has dropped, so a new transaction
// may start then. The single table memory read port sets one probe per cycle.
// Write transactions give no result. Reset clears table_size to zero and idles the
// sequencer; table contents are not cleared.
module sorted_table_binary_search_top #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
  parameter int ENTRY_WIDTH = stbs_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  stbs_pkg::stbs_in_t               in_data,
  output logic                             out_strobe,
  output stbs_pkg::stbs_out_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [stbs_pkg::SIZE_W-1:0]      cfg_data
);
  import stbs_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int NW    = $clog2(TABLE_DEPTH + 1);
  localparam int CW    = (NW > SIZE_W) ? NW : SIZE_W;
  localparam int XW    = (ENTRY_WIDTH > KEY_W) ? ENTRY_WIDTH : KEY_W;

  logic [SIZE_W-1:0]      table_size_r;
  logic [NW-1:0]          num_entries;
  logic signed [XW-1:0]   val_x;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [ENTRY_WIDTH-1:0] wr_data;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [ENTRY_WIDTH-1:0] rd_data;

  // Configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      table_size_r <= cfg_data;
    end
  end

  // Clamp the searched count to the table depth
  assign num_entries = (CW'(table_size_r) > CW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH)
                                                               : NW'(table_size_r);

  // Write path: drop out-of-range indexes, cut value to entry width
  assign val_x   = XW'(in_data.entry_value);
  assign wr_data = val_x[ENTRY_WIDTH-1:0];
  assign wr_addr = IDX_W'(in_data.entry_index);
  assign wr_en   = start && !busy && (in_data.req_type == REQ_WRITE)
                   && (32'(in_data.entry_index) < 32'(TABLE_DEPTH));

  stbs_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENTRY_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  stbs_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .req_type    (in_data.req_type),
    .search_key  (in_data.search_key),
    .num_entries (num_entries),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .out_strobe  (out_strobe),
    .out_data    (out_data)
  );

endmodule
